// ----- hw/rtl/mtn_pkg.sv -----
`timescale 1ns / 1ps
package mtn_pkg;

  // Character codes
  localparam logic [7:0] SPACE    = 8'h20;
  localparam logic [7:0] DOLLAR   = 8'h24;
  localparam logic [7:0] EURO     = 8'h80;
  localparam logic [7:0] POUND    = 8'hA3;
  localparam logic [7:0] CENT     = 8'hA2;
  localparam logic [7:0] LOWER_C  = 8'h63;
  localparam logic [7:0] DOT      = 8'h2E;
  localparam logic [7:0] COMMA    = 8'h2C;
  localparam logic [7:0] ZERO     = 8'h30;
  localparam logic [7:0] NINE     = 8'h39;

  // Window geometry
  localparam int unsigned WinDepth = 4;
  localparam int unsigned FillW    = 3;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       out_last;
  } out_req_t;

  // Verdict on one judged byte
  typedef struct packed {
    logic       emit;
    logic [7:0] obyte;
  } judge_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= ZERO) && (b <= NINE);
  endfunction

  function automatic logic is_money(input logic [7:0] b);
    return (b == EURO) || (b == POUND) || (b == CENT);
  endfunction

  function automatic logic [7:0] translate(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b == EURO || b == POUND) begin
      r = DOLLAR;
    end else if (b == CENT) begin
      r = LOWER_C;
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/monetary_text_normalizer.sv -----
`timescale 1ns / 1ps
// Money string normalizer.
// Input channel (in_valid / in_stall / in_data): one byte of the string per
// request, in_last set on its final byte. Output channel (out_valid /
// out_stall / out_data): normalized bytes, out_last set on the final one.
// A byte is decided once three bytes follow it, so mid-string a byte leaves
// in the request that arrives three requests later and appears on out_valid
// in the cycle after that request is taken. One request is accepted per
// cycle while in_stall is low. The request marked in_last starts a drain of
// the window: in_stall is high while each pending byte (up to 4) is judged
// and while the result buffer is full, each drain cycle yielding at most one
// result; the final byte always comes out with out_last.
// Results pass through a two-entry buffer, so a stall on the output holds
// back the input only once both entries are full; a stalled result holds.
// Reset (rst, synchronous) empties the window and the buffer; the block is
// ready for a new string in the first cycle after reset.
module monetary_text_normalizer (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  mtn_pkg::in_req_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output mtn_pkg::out_req_t out_data
);

  logic              can_push;
  logic              push;
  mtn_pkg::out_req_t push_data;

  mtn_core u_core (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .can_push  (can_push),
    .push      (push),
    .push_data (push_data)
  );

  mtn_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .can_push  (can_push),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- hw/rtl/mtn_judge.sv -----
`timescale 1ns / 1ps
// Decides one byte from itself, the byte before it and three bytes ahead.
module mtn_judge (
  input  logic [7:0]      cur,
  input  logic [7:0]      n1,
  input  logic [7:0]      n2,
  input  logic [7:0]      n3,
  input  logic [7:0]      prior,
  input  logic            first,
  output mtn_pkg::judge_t res
);

  always_comb begin
    res.emit  = 1'b1;
    res.obyte = cur;
    priority if (first || mtn_pkg::is_money(cur)) begin
      res.obyte = mtn_pkg::translate(cur);
    end else if (cur == mtn_pkg::DOT || cur == mtn_pkg::COMMA) begin
      // decimal mark between digits; dropped as a thousands mark
      if (mtn_pkg::is_digit(prior) && mtn_pkg::is_digit(n1)) begin
        if (mtn_pkg::is_digit(n3)) begin
          res.emit = 1'b0;
        end else begin
          res.obyte = mtn_pkg::DOT;
        end
      end
    end else if (cur == mtn_pkg::SPACE) begin
      // space used as a thousands separator
      if (mtn_pkg::is_digit(prior) && n1 == mtn_pkg::ZERO &&
          n2 == mtn_pkg::ZERO && n3 == mtn_pkg::ZERO) begin
        res.emit = 1'b0;
      end
    end else begin
      res.obyte = cur;
    end
  end

endmodule

// ----- hw/rtl/mtn_outbuf.sv -----
`timescale 1ns / 1ps
// Two-entry result buffer; absorbs receiver stalls until both entries are full.
module mtn_outbuf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  mtn_pkg::out_req_t push_data,
  output logic              can_push,
  output logic              out_valid,
  input  logic              out_stall,
  output mtn_pkg::out_req_t out_data
);

  mtn_pkg::out_req_t slots [2];
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] count;
  logic [1:0] count_next;
  logic       pop;

  assign out_valid = (count != 2'd0);
  assign out_data  = slots[rd_ptr];
  assign can_push  = (count != 2'd2);
  assign pop       = out_valid && !out_stall;

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 2'd1;
    end else if (!push && pop) begin
      count_next = count - 2'd1;
    end
  end

  // pointers and fill
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
    end
  end

  // payload storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

// ----- hw/rtl/mtn_core.sv -----
`timescale 1ns / 1ps
// Look-ahead window, string state and end-of-string drain.
module mtn_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  mtn_pkg::in_req_t  in_data,
  input  logic              can_push,
  output logic              push,
  output mtn_pkg::out_req_t push_data
);

  localparam logic [mtn_pkg::FillW-1:0] FILL_ONE   = mtn_pkg::FillW'(1);
  localparam logic [mtn_pkg::FillW-1:0] FILL_TWO   = mtn_pkg::FillW'(2);
  localparam logic [mtn_pkg::FillW-1:0] FILL_THREE = mtn_pkg::FillW'(3);
  localparam logic [mtn_pkg::FillW-1:0] FILL_FULL = mtn_pkg::FillW'(mtn_pkg::WinDepth - 1);

  logic [7:0]               win [mtn_pkg::WinDepth];
  logic [7:0]               win_next [mtn_pkg::WinDepth];
  logic [mtn_pkg::FillW-1:0] fill, fill_next;
  logic [7:0]               prior, prior_next;
  logic                     first, first_next;
  logic                     flushing, flushing_next;

  logic [7:0]      j_cur, j_n1, j_n2, j_n3;
  mtn_pkg::judge_t verdict;
  logic            accept;

  assign in_stall = flushing || !can_push;
  assign accept   = in_valid && !in_stall;

  // judge inputs: drain reads the window, steady state takes the new byte as n3
  always_comb begin
    j_cur = win[0];
    if (flushing) begin
      j_n1 = (fill > FILL_ONE)   ? win[1] : mtn_pkg::SPACE;
      j_n2 = (fill > FILL_TWO)   ? win[2] : mtn_pkg::SPACE;
      j_n3 = (fill > FILL_THREE) ? win[3] : mtn_pkg::SPACE;
    end else begin
      j_n1 = win[1];
      j_n2 = win[2];
      j_n3 = in_data.in_byte;
    end
  end

  mtn_judge u_judge (
    .cur   (j_cur),
    .n1    (j_n1),
    .n2    (j_n2),
    .n3    (j_n3),
    .prior (prior),
    .first (first),
    .res   (verdict)
  );

  // next state and result
  always_comb begin
    win_next      = win;
    fill_next     = fill;
    prior_next    = prior;
    first_next    = first;
    flushing_next = flushing;
    push          = 1'b0;
    push_data     = '0;
    if (flushing) begin
      if (can_push) begin
        push               = verdict.emit || (fill == FILL_ONE);
        push_data.out_byte = verdict.emit ? verdict.obyte : 8'h00;
        push_data.has_byte = verdict.emit;
        push_data.out_last = (fill == FILL_ONE);
        win_next[0] = win[1];
        win_next[1] = win[2];
        win_next[2] = win[3];
        fill_next   = fill - FILL_ONE;
        prior_next  = win[0];
        first_next  = 1'b0;
        if (fill == FILL_ONE) begin
          // string done: back to the idle state
          flushing_next = 1'b0;
          fill_next     = '0;
          prior_next    = mtn_pkg::SPACE;
          first_next    = 1'b1;
        end
      end
    end else if (accept) begin
      if (in_data.in_last) begin
        win_next[fill[1:0]] = in_data.in_byte;
        fill_next           = fill + FILL_ONE;
        flushing_next       = 1'b1;
      end else if (fill == FILL_FULL) begin
        push               = verdict.emit;
        push_data.out_byte = verdict.obyte;
        push_data.has_byte = 1'b1;
        push_data.out_last = 1'b0;
        win_next[0] = win[1];
        win_next[1] = win[2];
        win_next[2] = in_data.in_byte;
        prior_next  = win[0];
        first_next  = 1'b0;
      end else begin
        win_next[fill[1:0]] = in_data.in_byte;
        fill_next           = fill + FILL_ONE;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      fill     <= '0;
      prior    <= mtn_pkg::SPACE;
      first    <= 1'b1;
      flushing <= 1'b0;
    end else begin
      fill     <= fill_next;
      prior    <= prior_next;
      first    <= first_next;
      flushing <= flushing_next;
    end
  end

  // window bytes, no reset
  always_ff @(posedge clk) begin
    win <= win_next;
  end

endmodule

// ----- hw/rtl/mtn_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks on the normalizer.
module mtn_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input mtn_pkg::in_req_t  in_data,
  input logic              out_valid,
  input logic              out_stall,
  input mtn_pkg::out_req_t out_data
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result does not change
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result changed while stalled");

  // the final request of a string starts the drain
  a_drain_stall: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && in_data.in_last |=> in_stall)
    else $error("no drain after final request");

  // currency codes never leave untranslated
  a_no_currency: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.out_byte != mtn_pkg::EURO &&
                   out_data.out_byte != mtn_pkg::POUND &&
                   out_data.out_byte != mtn_pkg::CENT))
    else $error("currency byte passed through");

  // a bare marker only ends a string
  a_marker_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.has_byte |-> out_data.out_last)
    else $error("bare marker mid-string");

endmodule

bind monetary_text_normalizer mtn_checker u_mtn_checker (.*);

// ----- sim/monetary_text_normalizer_tb.sv -----
`timescale 1ns / 1ps
module monetary_text_normalizer_tb;

  // Directed rows: request, whether the result is typed in, typed result
  typedef struct packed {
    mtn_pkg::in_req_t  req;
    logic              typed;
    mtn_pkg::out_req_t res;
  } dir_row_t;

  localparam logic              CHECK_PRED  = 1'b0;
  localparam logic              CHECK_TYPED = 1'b1;
  localparam mtn_pkg::out_req_t NO_RES      = '0;
  localparam int                DIR_ROWS    = 24;
  localparam int                RAND_ITEMS  = 236;

  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    // one-byte strings: extremes and the currencies
    {8'h00,          1'b1, CHECK_TYPED, 8'h00,            1'b1, 1'b1},
    {8'hFF,          1'b1, CHECK_TYPED, 8'hFF,            1'b1, 1'b1},
    {mtn_pkg::EURO,  1'b1, CHECK_TYPED, mtn_pkg::DOLLAR,  1'b1, 1'b1},
    {mtn_pkg::POUND, 1'b1, CHECK_TYPED, mtn_pkg::DOLLAR,  1'b1, 1'b1},
    {mtn_pkg::CENT,  1'b1, CHECK_TYPED, mtn_pkg::LOWER_C, 1'b1, 1'b1},
    // "1,234": separator dropped, digit three ahead
    {8'h31,          1'b0, CHECK_PRED,  NO_RES},
    {mtn_pkg::COMMA, 1'b0, CHECK_PRED,  NO_RES},
    {8'h32,          1'b0, CHECK_PRED,  NO_RES},
    {8'h33,          1'b0, CHECK_PRED,  NO_RES},
    {8'h34,          1'b1, CHECK_PRED,  NO_RES},
    // "1.50": decimal point kept
    {8'h31,          1'b0, CHECK_PRED,  NO_RES},
    {mtn_pkg::DOT,   1'b0, CHECK_PRED,  NO_RES},
    {8'h35,          1'b0, CHECK_PRED,  NO_RES},
    {mtn_pkg::ZERO,  1'b1, CHECK_PRED,  NO_RES},
    // "5 000": thousands space dropped
    {8'h35,          1'b0, CHECK_PRED,  NO_RES},
    {mtn_pkg::SPACE, 1'b0, CHECK_PRED,  NO_RES},
    {mtn_pkg::ZERO,  1'b0, CHECK_PRED,  NO_RES},
    {mtn_pkg::ZERO,  1'b0, CHECK_PRED,  NO_RES},
    {mtn_pkg::ZERO,  1'b1, CHECK_PRED,  NO_RES},
    // leading comma left alone
    {mtn_pkg::COMMA, 1'b0, CHECK_PRED,  NO_RES},
    {8'h35,          1'b1, CHECK_PRED,  NO_RES},
    // currencies after the first byte
    {8'h39,          1'b0, CHECK_PRED,  NO_RES},
    {mtn_pkg::CENT,  1'b0, CHECK_PRED,  NO_RES},
    {mtn_pkg::POUND, 1'b1, CHECK_PRED,  NO_RES}
  };

  logic              clk = 1'b0;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  mtn_pkg::in_req_t  in_data;
  logic              out_valid;
  logic              out_stall;
  mtn_pkg::out_req_t out_data;

  // Typed expectation travelling with the offered request
  logic              typed_on;
  mtn_pkg::out_req_t typed_res;

  // Stimulus mode: quiet is shared by both sides, hold_req drives the receiver
  logic quiet;
  logic hold_req;

  int unsigned err_cnt;

  // Predictor state
  logic [7:0]        win_q [mtn_pkg::WinDepth];
  int unsigned       win_fill;
  logic [7:0]        prev_byte;
  logic              first_pending;
  mtn_pkg::out_req_t pending_norm_q [$];

  monetary_text_normalizer u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------
  function automatic logic num_byte(input logic [7:0] b);
    return (b >= mtn_pkg::ZERO) && (b <= mtn_pkg::NINE);
  endfunction

  function automatic logic [7:0] win_at(input int unsigned k);
    return (k < win_fill) ? win_q[k] : mtn_pkg::SPACE;
  endfunction

  function automatic logic [7:0] pick_currency();
    case ($urandom_range(2))
      0:       return mtn_pkg::EURO;
      1:       return mtn_pkg::POUND;
      default: return mtn_pkg::CENT;
    endcase
  endfunction

  function automatic logic [7:0] pick_sep();
    case ($urandom_range(2))
      0:       return mtn_pkg::DOT;
      1:       return mtn_pkg::COMMA;
      default: return mtn_pkg::SPACE;
    endcase
  endfunction

  task automatic clear_window();
    for (int k = 0; k < mtn_pkg::WinDepth; k++) win_q[k] = 8'h00;
    win_fill      = 0;
    prev_byte     = mtn_pkg::SPACE;
    first_pending = 1'b1;
  endtask

  task automatic shift_window();
    for (int k = 0; k + 1 < mtn_pkg::WinDepth; k++) win_q[k] = win_q[k + 1];
    win_q[mtn_pkg::WinDepth - 1] = 8'h00;
    if (win_fill > 0) win_fill--;
  endtask

  // Decide the head byte of the window
  task automatic judge_head(output logic emit, output logic [7:0] ob);
    logic [7:0] cur, n1, n2, n3;
    cur  = win_at(0);
    n1   = win_at(1);
    n2   = win_at(2);
    n3   = win_at(3);
    emit = 1'b1;
    ob   = cur;
    if (first_pending || cur == mtn_pkg::EURO || cur == mtn_pkg::POUND ||
        cur == mtn_pkg::CENT) begin
      if (cur == mtn_pkg::CENT) begin
        ob = mtn_pkg::LOWER_C;
      end else if (cur == mtn_pkg::EURO || cur == mtn_pkg::POUND) begin
        ob = mtn_pkg::DOLLAR;
      end
      first_pending = 1'b0;
    end else if (cur == mtn_pkg::DOT || cur == mtn_pkg::COMMA) begin
      if (num_byte(prev_byte) && num_byte(n1)) begin
        if (num_byte(n3)) emit = 1'b0;
        else ob = mtn_pkg::DOT;
      end
    end else if (cur == mtn_pkg::SPACE) begin
      if (num_byte(prev_byte) && n1 == mtn_pkg::ZERO && n2 == mtn_pkg::ZERO &&
          n3 == mtn_pkg::ZERO) emit = 1'b0;
    end
    prev_byte = cur;
  endtask

  // Work out the results one accepted request causes
  task automatic normalize_request(input mtn_pkg::in_req_t r, input logic push_res);
    mtn_pkg::out_req_t res [4];
    int unsigned       n;
    logic              emit;
    logic [7:0]        ob;
    n = 0;
    if (win_fill >= mtn_pkg::WinDepth) win_fill = mtn_pkg::WinDepth - 1;
    win_q[win_fill] = r.in_byte;
    win_fill++;
    if (!r.in_last) begin
      if (win_fill >= mtn_pkg::WinDepth) begin
        judge_head(emit, ob);
        if (emit) begin
          res[0] = {ob, 1'b1, 1'b0};
          n = 1;
        end
        shift_window();
      end
    end else begin
      // flush the whole window
      while (win_fill > 0 && n < 4) begin
        judge_head(emit, ob);
        if (emit) begin
          res[n] = {ob, 1'b1, 1'b0};
          n++;
        end
        shift_window();
      end
      if (n == 0) begin
        res[0] = {8'h00, 1'b0, 1'b1};
        n = 1;
      end else begin
        res[n - 1].out_last = 1'b1;
      end
      clear_window();
    end
    if (push_res) begin
      for (int k = 0; k < n; k++) pending_norm_q.push_back(res[k]);
    end
  endtask

  // ---------------------------------------------------------------------
  // Monitor: predict on input accept, compare on output accept
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    mtn_pkg::out_req_t exp_res;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (pending_norm_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %02h/%0b/%0b", $time,
                   out_data.out_byte, out_data.has_byte, out_data.out_last);
          err_cnt++;
        end else begin
          exp_res = pending_norm_q.pop_front();
          if (out_data.out_byte !== exp_res.out_byte) begin
            $display("%0t: out_byte expected %02h, got %02h", $time,
                     exp_res.out_byte, out_data.out_byte);
            err_cnt++;
          end
          if (out_data.has_byte !== exp_res.has_byte) begin
            $display("%0t: has_byte expected %0b, got %0b", $time,
                     exp_res.has_byte, out_data.has_byte);
            err_cnt++;
          end
          if (out_data.out_last !== exp_res.out_last) begin
            $display("%0t: out_last expected %0b, got %0b", $time,
                     exp_res.out_last, out_data.out_last);
            err_cnt++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        normalize_request(in_data, !typed_on);
        if (typed_on) pending_norm_q.push_back(typed_res);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Receiver: random stalls, one long hold-off to back up the input
  // ---------------------------------------------------------------------
  initial begin
    int  hold_left;
    logic hold_done;
    out_stall = 1'b0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        hold_left = 80;
        hold_done = 1'b1;
      end else if (quiet) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 35);
      end
    end
  end

  // Offer one request; entered and left at a falling edge
  task automatic send_req(input mtn_pkg::in_req_t r, input logic typed,
                          input mtn_pkg::out_req_t res);
    while (!quiet && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_data   <= r;
    typed_on  <= typed;
    typed_res <= res;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    logic [7:0]       str_q [$];
    mtn_pkg::in_req_t r;
    int unsigned      n_sent;
    int unsigned      len;
    int unsigned      pick;
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    typed_on  = 1'b0;
    typed_res = '0;
    quiet     = 1'b0;
    hold_req  = 1'b0;
    err_cnt   = 0;
    n_sent    = 0;
    clear_window();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table
    for (int i = 0; i < DIR_ROWS; i++) begin
      send_req(DIR_TAB[i].req, DIR_TAB[i].typed, DIR_TAB[i].res);
    end

    // random money strings, some noise
    while (n_sent < RAND_ITEMS) begin
      quiet = (n_sent >= 100 && n_sent < 160);
      if (n_sent >= 180) hold_req = 1'b1;
      str_q.delete();
      if ($urandom_range(7) == 0) begin
        len = $urandom_range(1, 8);
        repeat (len) str_q.push_back(8'($urandom_range(255)));
      end else begin
        if ($urandom_range(2) == 0) str_q.push_back(pick_currency());
        len = $urandom_range(1, 8);
        repeat (len) begin
          pick = $urandom_range(15);
          if (pick < 7 || pick > 13) begin
            str_q.push_back(mtn_pkg::ZERO + 8'($urandom_range(9)));
          end else if (pick == 7) begin
            // thousands group
            str_q.push_back(pick_sep());
            repeat (3) str_q.push_back(mtn_pkg::ZERO);
          end else if (pick == 8) begin
            str_q.push_back(pick_sep());
            repeat ($urandom_range(1, 3))
              str_q.push_back(mtn_pkg::ZERO + 8'($urandom_range(9)));
          end else if (pick == 9) begin
            str_q.push_back(pick_currency());
          end else if (pick == 10) begin
            str_q.push_back(pick_sep());
          end else if (pick == 11) begin
            str_q.push_back(mtn_pkg::ZERO);
          end else begin
            str_q.push_back(8'($urandom_range(255)));
          end
        end
      end
      for (int k = 0; k < str_q.size(); k++) begin
        r.in_byte = str_q[k];
        r.in_last = (k == str_q.size() - 1);
        send_req(r, CHECK_PRED, NO_RES);
        n_sent++;
      end
    end
    in_valid <= 1'b0;
    quiet    = 1'b0;

    // drain and let the block settle
    while (pending_norm_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #400000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/mtn_pkg.sv
hw/rtl/mtn_judge.sv
hw/rtl/mtn_outbuf.sv
hw/rtl/mtn_core.sv
hw/rtl/monetary_text_normalizer.sv
hw/rtl/mtn_checker.sv
sim/monetary_text_normalizer_tb.sv
